@@ hdl/clcg_pkg.sv @@
package clcg_pkg;

  localparam int FRACTION_BITS = 24;
  localparam int LANES         = 3;
  localparam int SEED_W        = 15;
  localparam int RANGE_W       = 16;
  localparam int QUOT_W        = 8;
  localparam int REM_W         = 8;
  localparam int RECIP_W       = 16;
  localparam int RECIP_SHIFT   = 22;
  localparam int WEIGHT_W      = 30;
  localparam int PROD_W        = WEIGHT_W + SEED_W;
  localparam int DEN_W         = 45;
  localparam int NUM_W         = DEN_W + 2;
  localparam int DEN_LO_W      = 23;
  localparam int DEN_HI_W      = DEN_W - DEN_LO_W;
  localparam int FRAC_RECIP_W  = FRACTION_BITS + 1;
  localparam int EST_W         = DEN_W + FRAC_RECIP_W;
  localparam int RP_LO_W       = DEN_LO_W + FRAC_RECIP_W;
  localparam int RP_HI_W       = DEN_HI_W + FRAC_RECIP_W;
  localparam int BP_LO_W       = DEN_LO_W + FRACTION_BITS;
  localparam int BP_HI_W       = DEN_HI_W + FRACTION_BITS;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam longint unsigned MOD_A = 64'd30269;
  localparam longint unsigned MOD_B = 64'd30307;
  localparam longint unsigned MOD_C = 64'd30323;

  localparam logic [DEN_W-1:0] DEN = DEN_W'(MOD_A * MOD_B * MOD_C);

  localparam logic [FRAC_RECIP_W-1:0] FRAC_RECIP =
    FRAC_RECIP_W'((EST_W'(1) << (DEN_W + FRACTION_BITS)) / EST_W'(DEN));

  localparam logic [WEIGHT_W-1:0] WEIGHT [LANES] = '{
    WEIGHT_W'(MOD_B * MOD_C), WEIGHT_W'(MOD_A * MOD_C), WEIGHT_W'(MOD_A * MOD_B)
  };
  localparam logic [SEED_W-1:0] MODULUS [LANES] = '{
    SEED_W'(MOD_A), SEED_W'(MOD_B), SEED_W'(MOD_C)
  };
  localparam logic [7:0] MULT [LANES] = '{8'd171, 8'd172, 8'd170};
  localparam logic [7:0] DIVR [LANES] = '{8'd177, 8'd176, 8'd178};
  localparam logic [7:0] SREM [LANES] = '{8'd2, 8'd35, 8'd63};
  localparam logic [RECIP_W-1:0] RECIP [LANES] = '{
    RECIP_W'((32'd1 << RECIP_SHIFT) / 32'd177),
    RECIP_W'((32'd1 << RECIP_SHIFT) / 32'd176),
    RECIP_W'((32'd1 << RECIP_SHIFT) / 32'd178)
  };
  localparam logic [SEED_W-1:0] SEED_RESET [LANES] = '{15'd123, 15'd7131, 15'd30013};

  typedef struct packed {
    logic [RANGE_W-1:0] range_max;
    logic               zero;
  } q_item_t;

  typedef struct packed {
    logic                         valid;
    logic [LANES-1:0][SEED_W-1:0] seed;
  } seed_load_t;

  typedef struct packed {
    logic             inc;
    logic [REM_W-1:0] rem;
  } qr_t;

  function automatic logic [QUOT_W-1:0] quot_est(input logic [SEED_W-1:0] s,
                                                 input logic [RECIP_W-1:0] recip);
    logic [SEED_W+RECIP_W-1:0] p;
    p = (SEED_W + RECIP_W)'(s) * (SEED_W + RECIP_W)'(recip);
    return p[RECIP_SHIFT +: QUOT_W];
  endfunction

  function automatic qr_t rem_fix(input logic [SEED_W-1:0] s,
                                  input logic [QUOT_W-1:0] q,
                                  input logic [7:0] d);
    logic [15:0] prod;
    logic [15:0] diff;
    qr_t         r;
    prod = 16'(q) * 16'(d);
    diff = 16'(s) - prod;
    if (diff >= 16'(d)) begin
      r.inc = 1'b1;
      r.rem = REM_W'(diff - 16'(d));
    end else begin
      r.inc = 1'b0;
      r.rem = REM_W'(diff);
    end
    return r;
  endfunction

endpackage

@@ hdl/clcg_front.sv @@
module clcg_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [clcg_pkg::RANGE_W-1:0]  range_max,
  input  logic                          hold,
  output logic                          q_valid,
  output clcg_pkg::q_item_t             q_item,
  input  logic                          q_pop
);
  import clcg_pkg::*;

  q_item_t             entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                push;
  logic                pop;

  assign in_stall = (count == QCNT_W'(QUEUE_DEPTH)) || hold;
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr].range_max <= range_max;
      entry[wr_ptr].zero      <= (range_max == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hdl/clcg_reseed.sv @@
module clcg_reseed (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [clcg_pkg::SEED_W-1:0]  seed_value,
  output logic                         busy,
  output clcg_pkg::seed_load_t         load
);
  import clcg_pkg::*;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_QUOT  = 2'd1;
  localparam logic [1:0] PH_REM   = 2'd2;
  localparam logic [1:0] PH_LOAD  = 2'd3;

  logic [1:0]        phase;
  logic [SEED_W-1:0] s;
  logic [QUOT_W-1:0] quot [LANES];
  logic [REM_W-1:0]  rmd  [LANES];
  qr_t               fixed [LANES];

  assign busy      = (phase != PH_IDLE);
  assign cfg_ready = !busy;

  always_comb begin
    load.valid = (phase == PH_LOAD);
    for (int i = 0; i < LANES; i++) begin
      load.seed[i] = SEED_W'(16'(MULT[i]) * 16'(rmd[i]));
      fixed[i]     = rem_fix(s, quot[i], DIVR[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_valid && cfg_ready) begin
      s <= seed_value;
    end
    for (int i = 0; i < LANES; i++) begin
      if (phase == PH_QUOT) begin
        quot[i] <= quot_est(s, RECIP[i]);
      end
      if (phase == PH_REM) begin
        rmd[i] <= fixed[i].rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      case (phase)
        PH_IDLE: begin
          if (cfg_valid) begin
            phase <= PH_QUOT;
          end
        end
        PH_QUOT: phase <= PH_REM;
        PH_REM:  phase <= PH_LOAD;
        PH_LOAD: phase <= PH_IDLE;
        default: phase <= PH_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/clcg_back.sv @@
module clcg_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_valid,
  input  clcg_pkg::q_item_t                   q_item,
  output logic                                q_pop,
  input  clcg_pkg::seed_load_t                load,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [clcg_pkg::FRACTION_BITS-1:0]  fraction,
  output logic [clcg_pkg::RANGE_W-1:0]        scaled_value
);
  import clcg_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_QUOT   = 4'd1;
  localparam logic [3:0] ST_FIX    = 4'd2;
  localparam logic [3:0] ST_STEP   = 4'd3;
  localparam logic [3:0] ST_PROD   = 4'd4;
  localparam logic [3:0] ST_SUM    = 4'd5;
  localparam logic [3:0] ST_REDUCE = 4'd6;
  localparam logic [3:0] ST_RECIP  = 4'd7;
  localparam logic [3:0] ST_EST    = 4'd8;
  localparam logic [3:0] ST_MULB   = 4'd9;
  localparam logic [3:0] ST_DIFF   = 4'd10;
  localparam logic [3:0] ST_FIXUP  = 4'd11;
  localparam logic [3:0] ST_SCALE  = 4'd12;
  localparam logic [3:0] ST_DONE   = 4'd13;

  localparam int SPROD_W = RANGE_W + FRACTION_BITS;

  logic [3:0]               state;
  logic [SEED_W-1:0]        seed  [LANES];
  logic [QUOT_W-1:0]        quot  [LANES];
  logic [REM_W-1:0]         rmd   [LANES];
  logic [PROD_W-1:0]        prod  [LANES];
  logic [SEED_W-1:0]        stepped [LANES];
  qr_t                      fixed [LANES];
  logic [NUM_W-1:0]         acc;
  logic [NUM_W-1:0]         sum;
  logic [RP_LO_W-1:0]       rp_lo;
  logic [RP_HI_W-1:0]       rp_hi;
  logic [EST_W-1:0]         est_sum;
  logic [FRACTION_BITS-1:0] q_est;
  logic [BP_LO_W-1:0]       bp_lo;
  logic [BP_HI_W-1:0]       bp_hi;
  logic [NUM_W-1:0]         back_sum;
  logic [NUM_W-1:0]         rem_scaled;
  logic [NUM_W-1:0]         diff;
  logic [FRACTION_BITS-1:0] frac;
  logic [RANGE_W-1:0]       range_r;
  logic                     zero_r;
  logic [SPROD_W-1:0]       sprod;
  logic                     out_free;
  logic [RANGE_W-1:0]       scaled;

  assign q_pop      = (state == ST_IDLE) && q_valid;
  assign out_free   = !out_valid || !out_stall;
  assign sum        = NUM_W'(prod[0]) + NUM_W'(prod[1]) + NUM_W'(prod[2]);
  assign est_sum    = (EST_W'(rp_hi) << DEN_LO_W) + EST_W'(rp_lo);
  assign back_sum   = (NUM_W'(bp_hi) << DEN_LO_W) + NUM_W'(bp_lo);
  assign rem_scaled = {acc[NUM_W-FRACTION_BITS-1:0], {FRACTION_BITS{1'b0}}};
  assign scaled     = zero_r ? '0 : sprod[SPROD_W-1 -: RANGE_W] + 1'b1;

  always_comb begin
    logic [SEED_W-1:0]  p1;
    logic [SEED_W-1:0]  p2;
    logic signed [16:0] v;
    p1 = '0;
    p2 = '0;
    v  = '0;
    for (int i = 0; i < LANES; i++) begin
      fixed[i] = rem_fix(seed[i], quot[i], DIVR[i]);
      p1 = SEED_W'(16'(MULT[i]) * 16'(rmd[i]));
      p2 = SEED_W'(16'(SREM[i]) * 16'(quot[i]));
      v  = $signed({2'b00, p1}) - $signed({2'b00, p2});
      if (v < 0) begin
        v = v + $signed({2'b00, MODULUS[i]});
      end
      stepped[i] = v[SEED_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      range_r <= q_item.range_max;
      zero_r  <= q_item.zero;
    end
    for (int i = 0; i < LANES; i++) begin
      if (state == ST_QUOT) begin
        quot[i] <= quot_est(seed[i], RECIP[i]);
      end
      if (state == ST_FIX) begin
        quot[i] <= quot[i] + QUOT_W'(fixed[i].inc);
        rmd[i]  <= fixed[i].rem;
      end
      if (state == ST_PROD) begin
        prod[i] <= PROD_W'(seed[i]) * PROD_W'(WEIGHT[i]);
      end
    end
    case (state)
      ST_SUM: acc <= sum;
      ST_REDUCE: begin
        if (acc >= NUM_W'(DEN)) begin
          acc <= acc - NUM_W'(DEN);
        end
      end
      ST_RECIP: begin
        rp_lo <= RP_LO_W'(acc[DEN_LO_W-1:0]) * RP_LO_W'(FRAC_RECIP);
        rp_hi <= RP_HI_W'(acc[DEN_W-1:DEN_LO_W]) * RP_HI_W'(FRAC_RECIP);
      end
      ST_EST: q_est <= est_sum[DEN_W +: FRACTION_BITS];
      ST_MULB: begin
        bp_lo <= BP_LO_W'(q_est) * BP_LO_W'(DEN[DEN_LO_W-1:0]);
        bp_hi <= BP_HI_W'(q_est) * BP_HI_W'(DEN[DEN_W-1:DEN_LO_W]);
      end
      ST_DIFF: diff <= rem_scaled - back_sum;
      ST_FIXUP: frac <= q_est + FRACTION_BITS'(diff >= NUM_W'(DEN));
      ST_SCALE: sprod <= SPROD_W'(range_r) * SPROD_W'(frac);
      default: begin
      end
    endcase
    if (state == ST_DONE && out_free) begin
      fraction     <= frac;
      scaled_value <= scaled;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < LANES; i++) begin
        seed[i] <= SEED_RESET[i];
      end
    end else begin
      if (load.valid) begin
        for (int i = 0; i < LANES; i++) begin
          seed[i] <= load.seed[i];
        end
      end else if (state == ST_STEP) begin
        for (int i = 0; i < LANES; i++) begin
          seed[i] <= stepped[i];
        end
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            state <= ST_QUOT;
          end
        end
        ST_QUOT: state <= ST_FIX;
        ST_FIX:  state <= ST_STEP;
        ST_STEP: state <= ST_PROD;
        ST_PROD: state <= ST_SUM;
        ST_SUM:  state <= ST_REDUCE;
        ST_REDUCE: begin
          if (acc < NUM_W'(DEN)) begin
            state <= ST_RECIP;
          end
        end
        ST_RECIP: state <= ST_EST;
        ST_EST:   state <= ST_MULB;
        ST_MULB:  state <= ST_DIFF;
        ST_DIFF:  state <= ST_FIXUP;
        ST_FIXUP: state <= ST_SCALE;
        ST_SCALE: state <= ST_DONE;
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/combined_lcg_random_generator.sv @@
// Combined three-generator uniform random source.
// Input channel (in_valid / in_stall, range_max): one beat requests one number.
// Output channel (out_valid / out_stall, fraction, scaled_value): one beat per
// request, in order. fraction is a 24-bit fraction in [0,1); scaled_value is
// 1 + floor(range_max * fraction), or 0 when range_max is 0.
// Seed channel (cfg_valid / cfg_ready, seed_value): a beat reloads the three
// generator states; cfg_ready drops while the new states are formed, and
// in_stall is held high over that time.
// A request passes through the input queue, the generator step (quotient
// estimate, remainder fix and step), the weighted sum (products and sum), the
// reduction (the modulus product is subtracted until the sum is below it),
// the fraction (reciprocal estimate, back multiply and one correction), then
// scaling and the output register. The back end works on one number at a
// time; a two-entry queue keeps taking requests while it works.
// When the receiver stalls, the result is held in the output register and
// the next one waits in the back end.
// Reset (rst, synchronous) restores the states to 123, 7131 and 30013 and
// empties the queue and the output register; it does not reseed.
module combined_lcg_random_generator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [clcg_pkg::RANGE_W-1:0]        range_max,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [clcg_pkg::FRACTION_BITS-1:0]  fraction,
  output logic [clcg_pkg::RANGE_W-1:0]        scaled_value,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [clcg_pkg::SEED_W-1:0]         seed_value
);
  import clcg_pkg::*;

  logic       busy;
  logic       q_valid;
  logic       q_pop;
  q_item_t    q_item;
  seed_load_t load;

  clcg_reseed u_reseed (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .seed_value (seed_value),
    .busy       (busy),
    .load       (load)
  );

  clcg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .range_max (range_max),
    .hold      (busy),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  clcg_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .load         (load),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .fraction     (fraction),
    .scaled_value (scaled_value)
  );

endmodule

@@ dv/combined_lcg_random_generator_tb.sv @@
`timescale 1ns / 1ps

module combined_lcg_random_generator_tb;
  import clcg_pkg::*;

  localparam longint unsigned M_FIRST  = 64'd30269;
  localparam longint unsigned M_SECOND = 64'd30307;
  localparam longint unsigned M_THIRD  = 64'd30323;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE_CYCLES = 45;
  localparam int IDLE_LIMIT   = 3000;
  localparam int RANDOM_ITEMS = 580;
  localparam int RANDOM_PHASES = 5;

  typedef struct packed {
    logic [FRACTION_BITS-1:0] fraction;
    logic [RANGE_W-1:0]       scaled_value;
  } rng_draw_t;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic [RANGE_W-1:0]       range_max;
  logic                     out_valid;
  logic                     out_stall;
  logic [FRACTION_BITS-1:0] fraction;
  logic [RANGE_W-1:0]       scaled_value;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [SEED_W-1:0]        seed_value;

  logic [SEED_W-1:0] gen_first;
  logic [SEED_W-1:0] gen_second;
  logic [SEED_W-1:0] gen_third;

  rng_draw_t pending_draws[$];
  int        mismatch_count = 0;
  int        idle_cycles    = 0;
  bit        sink_hold      = 1'b0;
  bit        sink_quiet     = 1'b0;
  bit        src_quiet      = 1'b0;

  combined_lcg_random_generator DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .range_max    (range_max),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .fraction     (fraction),
    .scaled_value (scaled_value),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .seed_value   (seed_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [SEED_W-1:0] schrage_step(input logic [SEED_W-1:0] s,
                                                     input int unsigned mul,
                                                     input int unsigned q,
                                                     input int unsigned r,
                                                     input int unsigned m);
    int v;
    v = int'(mul * (s % q)) - int'(r * (s / q));
    if (v < 0) begin
      v += int'(m);
    end
    return SEED_W'(v);
  endfunction

  function automatic rng_draw_t draw_next(input logic [RANGE_W-1:0] bound);
    longint unsigned den;
    longint unsigned num;
    longint unsigned rem;
    logic [FRACTION_BITS-1:0] frac;
    logic [RANGE_W+FRACTION_BITS-1:0] prod;
    rng_draw_t res;
    gen_first  = schrage_step(gen_first, 171, 177, 2, 30269);
    gen_second = schrage_step(gen_second, 172, 176, 35, 30307);
    gen_third  = schrage_step(gen_third, 170, 178, 63, 30323);
    den = M_FIRST * M_SECOND * M_THIRD;
    num = longint'(gen_first) * (M_SECOND * M_THIRD)
        + longint'(gen_second) * (M_FIRST * M_THIRD)
        + longint'(gen_third) * (M_FIRST * M_SECOND);
    rem = num % den;
    frac = '0;
    for (int i = 0; i < FRACTION_BITS; i++) begin
      rem = rem << 1;
      frac = {frac[FRACTION_BITS-2:0], 1'b0};
      if (rem >= den) begin
        rem = rem - den;
        frac[0] = 1'b1;
      end
    end
    prod = (RANGE_W + FRACTION_BITS)'(bound) * (RANGE_W + FRACTION_BITS)'(frac);
    res.fraction = frac;
    res.scaled_value = (bound == '0) ? '0 : RANGE_W'(prod >> FRACTION_BITS) + 1'b1;
    return res;
  endfunction

  function automatic void reseed_gens(input logic [SEED_W-1:0] s);
    gen_first  = SEED_W'(171 * (int'(s) % 177));
    gen_second = SEED_W'(172 * (int'(s) % 176));
    gen_third  = SEED_W'(170 * (int'(s) % 178));
  endfunction

  function automatic int pick_gap();
    int n;
    if (src_quiet) begin
      return 0;
    end
    n = $urandom_range(0, 19);
    if (n < 12) begin
      return 0;
    end else if (n < 18) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [RANGE_W-1:0] pick_range();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return RANGE_W'($urandom_range(1, 16));
      default: return RANGE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Keep valid high when gap is 0 so the next beat follows directly.
  task automatic send_draw(input logic [RANGE_W-1:0] bound, input int gap);
    in_valid  <= 1'b1;
    range_max <= bound;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    pending_draws.push_back(draw_next(bound));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (pending_draws.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_seed(input logic [SEED_W-1:0] s);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid  <= 1'b1;
    seed_value <= s;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    reseed_gens(s);
  endtask

  task automatic test_reset_sequence();
    logic [RANGE_W-1:0] bounds[10];
    bounds = '{16'd0, 16'd1, 16'hFFFF, 16'd2, 16'h8000, 16'hAAAA, 16'h5555,
               16'h7FFF, 16'd3, 16'd0};
    for (int i = 0; i < 10; i++) begin
      send_draw(bounds[i], (i == 9) ? 1 : i % 3);
    end
  endtask

  task automatic test_seed_extremes();
    logic [SEED_W-1:0] seeds[5];
    seeds = '{15'd0, 15'h7FFF, 15'd177, 15'd31328, 15'd1};
    foreach (seeds[i]) begin
      write_seed(seeds[i]);
      send_draw(16'hFFFF, 0);
      send_draw(16'd0, 1);
    end
  endtask

  task automatic test_output_hold_off();
    write_seed(SEED_W'($urandom_range(1, 32766)));
    sink_hold = 1'b1;
    for (int i = 0; i < 12; i++) begin
      send_draw(pick_range(), (i == 11) ? 1 : 0);
    end
  endtask

  task automatic test_drain_pause();
    for (int i = 0; i < 20; i++) begin
      send_draw(pick_range(), (i == 19) ? 1 : pick_gap());
    end
    wait_drained();
    for (int i = 0; i < 20; i++) begin
      send_draw(pick_range(), (i == 19) ? 1 : pick_gap());
    end
  endtask

  task automatic test_random_traffic();
    int per_phase;
    per_phase = RANDOM_ITEMS / RANDOM_PHASES;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_seed(SEED_W'($urandom_range(0, 32767)));
      src_quiet  = (p == 2);
      sink_quiet = (p == 2);
      for (int i = 0; i < per_phase; i++) begin
        send_draw(pick_range(), (i == per_phase - 1) ? 1 : pick_gap());
      end
    end
    src_quiet  = 1'b0;
    sink_quiet = 1'b0;
  endtask

  initial begin
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    range_max  <= '0;
    cfg_valid  <= 1'b0;
    seed_value <= '0;
    gen_first  = 15'd123;
    gen_second = 15'd7131;
    gen_third  = 15'd30013;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_sequence();
    test_seed_extremes();
    test_output_hold_off();
    test_drain_pause();
    test_random_traffic();
    wait_drained();
    repeat (50) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : sink_stall
    int n;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (sink_hold) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold = 1'b0;
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (sink_quiet || $urandom_range(0, 3) != 0) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_draws
    rng_draw_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_draws.size() == 0) begin
        $error("result beat with no draw pending: fraction %0d scaled_value %0d",
               fraction, scaled_value);
        mismatch_count++;
      end else begin
        want = pending_draws.pop_front();
        if (fraction !== want.fraction) begin
          $error("fraction: expected %0d, actual %0d", want.fraction, fraction);
          mismatch_count++;
        end
        if (scaled_value !== want.scaled_value) begin
          $error("scaled_value: expected %0d, actual %0d", want.scaled_value, scaled_value);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
